@@ rtl/gjfp_pkg.sv @@
// Shared types and constants for the Gauss-Jordan full-pivot split block.
// Holds the request/result structs, cell command codes and Q8.24 helpers.
// No dependencies.
package gjfp_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_TOL  = 2'd2;

  localparam int CFG_DW = 25;
  localparam int TOK_IW = 7;

  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef struct packed {
    op_t                opcode;
    logic [2:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic [3:0]         rank_found;
    logic               full_rank;
    logic [3:0]         dependent_col;
    logic [3:0]         independent_col;
    logic signed [31:0] coeff_value;
    logic signed [31:0] offset_value;
    logic               overflow;
  } res_t;

  // Commands broadcast to every column cell
  typedef enum logic [2:0] {
    CC_IDLE,
    CC_WRITE,
    CC_SEARCH,
    CC_DIV,
    CC_MUL,
    CC_LATCH
  } ccmd_t;

  typedef struct packed {
    ccmd_t              cmd;
    logic signed [31:0] operand;
  } cctl_t;

  // Running maximum handed from cell to cell
  typedef struct packed {
    logic [31:0]       mag;
    logic [TOK_IW-1:0] idx;
  } tok_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

endpackage

@@ rtl/gjfp_cell.sv @@
// One column cell of the augmented store: holds the column, a bit-serial
// divider, a multiply-subtract path and one stage of the max-search chain.
// Depends on gjfp_pkg.
module gjfp_cell #(
  parameter int J         = 0,
  parameter int MAX_ROWS  = 8,
  parameter int FRAC_BITS = 24,
  parameter int RW        = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gjfp_pkg::cctl_t           ctl,
  input  logic [RW-1:0]             row,
  input  logic                      active,
  input  logic                      search_en,
  input  logic                      sel,
  input  logic                      zero_sel,
  input  gjfp_pkg::tok_t            tok_in,
  output gjfp_pkg::tok_t            tok_out,
  output logic signed [31:0]        rd,
  output logic                      sat
);
  import gjfp_pkg::*;

  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);

  logic signed [31:0] mem [MAX_ROWS];
  logic signed [31:0] prow;

  // divider state
  logic [DW-1:0]  dnd;
  logic [31:0]    rem;
  logic [31:0]    dvs;
  logic           dneg;
  logic           dbusy;
  logic [DCW-1:0] dcnt;

  // multiplier state
  logic [63:0]    prod;
  logic           pneg;
  logic           mvld;

  logic [32:0]        trial;
  logic               q_over;
  logic signed [31:0] q_val;
  logic [63:0]        msh;
  logic               m_over;
  logic signed [31:0] m_val;
  logic [32:0]        diff;
  logic               d_over;
  logic signed [31:0] d_val;
  logic               div_fin;

  assign rd = mem[row];

  // Restoring division step and final saturation
  always_comb begin
    trial   = {rem, dnd[DW-1]};
    div_fin = dbusy && (dcnt == DCW'(DW));
    q_over  = (|dnd[DW-1:32]) || (dneg ? (dnd[31:0] > 32'h8000_0000) : dnd[31]);
    if (q_over) begin
      q_val = dneg ? SMIN : SMAX;
    end else begin
      q_val = dneg ? 32'(-dnd[31:0]) : dnd[31:0];
    end
  end

  // Product scaling, saturation and subtract
  always_comb begin
    msh    = prod >> FRAC_BITS;
    m_over = pneg ? (msh > 64'h8000_0000) : (msh > 64'h7fff_ffff);
    if (m_over) begin
      m_val = pneg ? SMIN : SMAX;
    end else begin
      m_val = pneg ? 32'(-msh[31:0]) : msh[31:0];
    end
    diff   = {rd[31], rd} - {m_val[31], m_val};
    d_over = diff[32] != diff[31];
    if (d_over) begin
      d_val = diff[32] ? SMIN : SMAX;
    end else begin
      d_val = diff[31:0];
    end
  end

  assign sat = (div_fin && q_over) || (mvld && (m_over || d_over));

  // Hold control of divider and multiplier pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy   <= 1'b0;
      dcnt    <= '0;
      mvld    <= 1'b0;
      tok_out <= '0;
    end else begin
      mvld <= (ctl.cmd == CC_MUL) && active;
      // advance the search chain
      if (ctl.cmd == CC_SEARCH && search_en && mag32(rd) > tok_in.mag) begin
        tok_out <= '{mag: mag32(rd), idx: TOK_IW'(J)};
      end else begin
        tok_out <= tok_in;
      end
      if (ctl.cmd == CC_DIV && active) begin
        dbusy <= 1'b1;
        dcnt  <= '0;
      end else if (div_fin) begin
        dbusy <= 1'b0;
      end else if (dbusy) begin
        dcnt <= dcnt + 1'b1;
      end
    end
  end

  // Datapath registers and the column store
  always_ff @(posedge clk) begin
    if (ctl.cmd == CC_DIV) begin
      dnd  <= {mag32(rd), {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dvs  <= mag32(ctl.operand);
      dneg <= rd[31] ^ ctl.operand[31];
    end else if (dbusy && !div_fin) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 32'(trial - {1'b0, dvs});
        dnd <= {dnd[DW-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        dnd <= {dnd[DW-2:0], 1'b0};
      end
    end
    if (ctl.cmd == CC_MUL) begin
      prod <= 64'(mag32(ctl.operand)) * 64'(mag32(prow));
      pneg <= ctl.operand[31] ^ prow[31];
    end
    if (ctl.cmd == CC_LATCH) begin
      prow <= rd;
    end
    if (ctl.cmd == CC_WRITE && sel) begin
      mem[row] <= ctl.operand;
    end else if (div_fin) begin
      mem[row] <= q_val;
    end else if (mvld) begin
      mem[row] <= zero_sel ? 32'sd0 : d_val;
    end
  end

endmodule

@@ rtl/gauss_jordan_full_pivot_split.sv @@
// Top level: sequencer over a chain of column cells that solves A x = b
// by Gauss-Jordan elimination with full pivoting. Depends on gjfp_pkg, gjfp_cell.
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  request   | start, busy, req                     | in (busy out)
//  result    | done, result                         | out
//  config    | cfg_valid, cfg_ready, cfg_index/data | in (cfg_ready out)
//
// Load and read requests are taken while idle and can stream back to back;
// a read result is registered and shows in the cycle after its request.
// A solve keeps busy high: per row a search pass through the cell chain,
// then unless the row is all zero a bit-serial divide in every active cell;
// per pivot a search over each free row (used rows are skipped), a divide to
// normalize the pivot row and a multiply-subtract for each other row; at the
// end a pass over the columns lists the free ones.
// Reset is synchronous; the result strobe cannot be stalled.
module gauss_jordan_full_pivot_split #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_COLS  = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  gjfp_pkg::req_t                req,
  output logic                          done,
  output gjfp_pkg::res_t                result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [gjfp_pkg::CFG_DW-1:0]   cfg_data
);
  import gjfp_pkg::*;

  localparam int NCELLS = MAX_COLS + 1;
  localparam int CW     = $clog2(NCELLS);
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NRW    = $clog2(MAX_ROWS + 1);
  localparam int LW     = $clog2(MAX_COLS);
  localparam int NCW    = $clog2(MAX_COLS + 1);
  localparam int DW     = 32 + FRAC_BITS;
  localparam int WTW    = $clog2(DW + NCELLS + 4);
  localparam logic signed [31:0] ONE_FX =
    (FRAC_BITS >= 31) ? SMAX : 32'(64'd1 << FRAC_BITS);
  localparam logic ONE_SAT = (FRAC_BITS >= 31);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_SRCH, ST_SC_DIV, ST_PV_SRCH, ST_EL_V, ST_EL_DIV,
    ST_EL_ONE, ST_EL_LATCH, ST_EL_ROW, ST_EL_MUL, ST_PV_NEXT, ST_IL, ST_DONE
  } state_t;

  state_t state;

  logic [2:0]        rows_cfg;
  logic [4:0]        cols_cfg;
  logic [24:0]       tol_cfg;

  logic [NCW-1:0]    nc;
  logic [NRW-1:0]    nr;
  logic [NRW-1:0]    i;
  logic [NRW-1:0]    rank;
  logic [RW-1:0]     br;
  logic [LW-1:0]     bc;
  logic [31:0]       best;
  logic [WTW-1:0]    cnt;
  logic [LW-1:0]     j;
  logic [LW-1:0]     k;
  logic signed [31:0] opnd;
  logic              sat_flag;

  logic [MAX_ROWS-1:0] row_pivoted;
  logic [MAX_COLS-1:0] col_pivoted;
  logic [LW-1:0]       pivot_col_of_row [MAX_ROWS];
  logic [LW-1:0]       indep_list [MAX_COLS];

  cctl_t               ctl;
  logic [RW-1:0]       row_sel;
  logic [NCELLS-1:0]   active;
  logic [NCELLS-1:0]   search_en;
  logic [NCELLS-1:0]   sel;
  logic [NCELLS-1:0]   zero_sel;
  logic [NCELLS-1:0]   cell_sat;
  tok_t                tok [NCELLS+1];
  logic signed [31:0]  cell_rd [NCELLS];

  logic              accept;
  logic              is_load;
  logic              row_ok;
  logic              rd_row_ok;
  logic              rd_col_ok;
  logic [LW-1:0]     ind;
  logic              scale_srch;
  logic              pv_srch;
  logic [31:0]       scale_div;
  logic              scale_sat;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_load   = (req.opcode == OP_LOAD_A) || (req.opcode == OP_LOAD_B);
  assign tok[0]    = '0;

  // Effective column and row counts
  always_comb begin
    int r;
    int lim;
    if (cols_cfg == 5'd0) begin
      nc = NCW'(1);
    end else if (32'(cols_cfg) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_cfg);
    end
    lim = 32'(nc) - 1;
    r   = 32'(rows_cfg);
    if (r > MAX_ROWS) r = MAX_ROWS;
    if (r > lim) r = lim;
    nr = NRW'(r);
  end

  // Read-side decode
  always_comb begin
    row_ok    = 32'(req.row_index) < MAX_ROWS;
    rd_row_ok = 32'(req.row_index) < 32'(nr);
    rd_col_ok = 32'(req.col_index) < (32'(nc) - 32'(nr));
    ind       = indep_list[LW'(req.col_index)];
    scale_srch = (state == ST_SC_SRCH);
    pv_srch    = (state == ST_PV_SRCH);
    scale_sat  = tok[NCELLS].mag[31];
    scale_div  = scale_sat ? 32'(SMAX) : tok[NCELLS].mag;
  end

  // Drive the cell chain
  always_comb begin
    ctl      = '{cmd: CC_IDLE, operand: opnd};
    row_sel  = i[RW-1:0];
    sel      = '0;
    zero_sel = '0;
    for (int c = 0; c < NCELLS; c++) begin
      if (c == MAX_COLS) begin
        active[c]    = 1'b1;
        search_en[c] = 1'b0;
      end else begin
        active[c]    = c < 32'(nc);
        search_en[c] = (c < 32'(nc)) && (scale_srch || !col_pivoted[c]);
      end
      zero_sel[c] = (c == 32'(bc));
    end
    case (state)
      ST_IDLE: begin
        row_sel     = RW'(req.row_index);
        ctl.operand = req.elem_value;
        if (accept && is_load) begin
          ctl.cmd = CC_WRITE;
        end
        for (int c = 0; c < NCELLS; c++) begin
          sel[c] = row_ok && ((req.opcode == OP_LOAD_B) ? (c == MAX_COLS) :
                              (c == 32'(req.col_index)));
        end
      end
      ST_SC_SRCH, ST_PV_SRCH: begin
        ctl.cmd = CC_SEARCH;
      end
      ST_SC_DIV: begin
        if (cnt == '0) ctl.cmd = CC_DIV;
      end
      ST_EL_V: begin
        row_sel = br;
      end
      ST_EL_DIV: begin
        row_sel = br;
        if (cnt == '0) ctl.cmd = CC_DIV;
      end
      ST_EL_ONE: begin
        row_sel     = br;
        ctl.cmd     = CC_WRITE;
        ctl.operand = ONE_FX;
        for (int c = 0; c < NCELLS; c++) sel[c] = (c == 32'(bc));
      end
      ST_EL_LATCH: begin
        row_sel = br;
        ctl.cmd = CC_LATCH;
      end
      ST_EL_MUL: begin
        if (cnt == '0) ctl.cmd = CC_MUL;
      end
      default: begin
        ctl.cmd = CC_IDLE;
      end
    endcase
  end

  // Column cells
  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    gjfp_cell #(
      .J         (c),
      .MAX_ROWS  (MAX_ROWS),
      .FRAC_BITS (FRAC_BITS),
      .RW        (RW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .row       (row_sel),
      .active    (active[c]),
      .search_en (search_en[c]),
      .sel       (sel[c]),
      .zero_sel  (zero_sel[c]),
      .tok_in    (tok[c]),
      .tok_out   (tok[c+1]),
      .rd        (cell_rd[c]),
      .sat       (cell_sat[c])
    );
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= '0;
      cols_cfg <= 5'd1;
      tol_cfg  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg <= cfg_data[2:0];
        CFG_COLS: cols_cfg <= cfg_data[4:0];
        CFG_TOL:  tol_cfg  <= cfg_data[24:0];
        default:  rows_cfg <= rows_cfg;
      endcase
    end
  end

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      result      <= '0;
      sat_flag    <= 1'b0;
      rank        <= '0;
      i           <= '0;
      cnt         <= '0;
      row_pivoted <= '0;
      col_pivoted <= '0;
      for (int r = 0; r < MAX_ROWS; r++) pivot_col_of_row[r] <= '0;
      for (int c = 0; c < MAX_COLS; c++) indep_list[c] <= '0;
    end else begin
      done <= 1'b0;
      if (|cell_sat) sat_flag <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (accept && req.opcode == OP_SOLVE) begin
            sat_flag    <= 1'b0;
            row_pivoted <= '0;
            col_pivoted <= '0;
            for (int r = 0; r < MAX_ROWS; r++) pivot_col_of_row[r] <= '0;
            for (int c = 0; c < MAX_COLS; c++) indep_list[c] <= '0;
            i     <= '0;
            cnt   <= '0;
            state <= ST_SC_SRCH;
          end else if (accept && req.opcode == OP_READ) begin
            done                   <= 1'b1;
            result.result_kind     <= 1'b1;
            result.rank_found      <= 4'(rank);
            result.full_rank       <= (rank == nr);
            result.dependent_col   <= rd_row_ok ? 4'(pivot_col_of_row[RW'(req.row_index)]) : 4'd0;
            result.offset_value    <= rd_row_ok ? cell_rd[MAX_COLS] : 32'sd0;
            result.independent_col <= rd_col_ok ? 4'(ind) : 4'd0;
            result.coeff_value     <= (rd_row_ok && rd_col_ok) ?
              ((cell_rd[CW'(ind)] == SMIN) ? SMAX : 32'(-cell_rd[CW'(ind)])) : 32'sd0;
            result.overflow        <= sat_flag;
          end
        end
        // scale each row by its largest magnitude
        ST_SC_SRCH: begin
          if (i >= nr) begin
            rank  <= '0;
            i     <= '0;
            best  <= '0;
            cnt   <= '0;
            state <= ST_PV_SRCH;
          end else if (cnt == WTW'(NCELLS)) begin
            cnt <= '0;
            if (tok[NCELLS].mag == 32'd0) begin
              i <= i + 1'b1;
            end else begin
              opnd <= scale_div;
              if (scale_sat) sat_flag <= 1'b1;
              state <= ST_SC_DIV;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SC_DIV: begin
          if (cnt == WTW'(DW + 2)) begin
            cnt   <= '0;
            i     <= i + 1'b1;
            state <= ST_SC_SRCH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        // find the pivot over free rows and columns
        ST_PV_SRCH: begin
          if (rank == nr) begin
            j     <= '0;
            k     <= '0;
            state <= ST_IL;
          end else if (i >= nr) begin
            if (best <= 32'(tol_cfg)) begin
              j     <= '0;
              k     <= '0;
              state <= ST_IL;
            end else begin
              state <= ST_EL_V;
            end
          end else if (row_pivoted[i[RW-1:0]]) begin
            i <= i + 1'b1;
          end else if (cnt == WTW'(NCELLS)) begin
            cnt <= '0;
            i   <= i + 1'b1;
            if (tok[NCELLS].mag > best) begin
              best <= tok[NCELLS].mag;
              br   <= i[RW-1:0];
              bc   <= LW'(tok[NCELLS].idx);
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EL_V: begin
          opnd  <= cell_rd[CW'(bc)];
          cnt   <= '0;
          state <= ST_EL_DIV;
        end
        ST_EL_DIV: begin
          if (cnt == WTW'(DW + 2)) begin
            cnt   <= '0;
            state <= ST_EL_ONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EL_ONE: begin
          if (ONE_SAT) sat_flag <= 1'b1;
          state <= ST_EL_LATCH;
        end
        ST_EL_LATCH: begin
          i     <= '0;
          state <= ST_EL_ROW;
        end
        // clear the pivot column in every other row
        ST_EL_ROW: begin
          if (i >= nr) begin
            state <= ST_PV_NEXT;
          end else if (i[RW-1:0] == br) begin
            i <= i + 1'b1;
          end else begin
            opnd  <= cell_rd[CW'(bc)];
            cnt   <= '0;
            state <= ST_EL_MUL;
          end
        end
        ST_EL_MUL: begin
          if (cnt == WTW'(1)) begin
            cnt   <= '0;
            i     <= i + 1'b1;
            state <= ST_EL_ROW;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_PV_NEXT: begin
          row_pivoted[br]      <= 1'b1;
          col_pivoted[bc]      <= 1'b1;
          pivot_col_of_row[br] <= bc;
          rank                 <= rank + 1'b1;
          i                    <= '0;
          best                 <= '0;
          cnt                  <= '0;
          state                <= ST_PV_SRCH;
        end
        // list the free columns
        ST_IL: begin
          if (32'(j) < 32'(nc) && !col_pivoted[j]) begin
            indep_list[k] <= j;
            k             <= k + 1'b1;
          end
          if (32'(j) == MAX_COLS - 1) begin
            state <= ST_DONE;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_DONE: begin
          done                   <= 1'b1;
          result.result_kind     <= 1'b0;
          result.rank_found      <= 4'(rank);
          result.full_rank       <= (rank == nr);
          result.dependent_col   <= 4'd0;
          result.independent_col <= 4'd0;
          result.coeff_value     <= 32'sd0;
          result.offset_value    <= 32'sd0;
          result.overflow        <= sat_flag || (|cell_sat);
          state                  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/gjfp_checker.sv @@
// Port-level checker for the Gauss-Jordan full-pivot split block, bound to
// the top level. Depends on gjfp_pkg and gauss_jordan_full_pivot_split.
module gjfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input gjfp_pkg::req_t req,
  input logic           done,
  input gjfp_pkg::res_t result
);
  import gjfp_pkg::*;

  // A read request answers with read data in the next cycle
  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode == OP_READ) |=> (done && result.result_kind))
    else $error("read request without read data");

  // A load request gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.opcode == OP_LOAD_A || req.opcode == OP_LOAD_B)) |=> !done)
    else $error("load request produced a result");

  // A solve ends with its status as busy drops
  a_solve_status: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done && !result.result_kind))
    else $error("busy dropped without a solve status");

  // A solve status only follows a busy period
  a_status_after_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !result.result_kind) |-> $past(busy))
    else $error("solve status outside a solve");

endmodule

bind gauss_jordan_full_pivot_split gjfp_checker u_gjfp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);

@@ tb/gjfp_split_checker.sv @@
// Checker for the Gauss-Jordan full-pivot split block: watches the request,
// result and config channels, predicts each result and compares it.
// Depends on gjfp_pkg.
`timescale 1ns / 100ps

module gjfp_split_checker
  import gjfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  req_t                req,
  input  logic                done,
  input  res_t                result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  output int                  mismatches,
  output int                  awaited
);

  localparam int NROW = 8;
  localparam int NCOL = 16;
  localparam int BCOL = NCOL;
  localparam int FB   = 24;

  // Shadow of the block's store, pivot bookkeeping and registers
  logic signed [31:0] store [NROW][NCOL+1];
  bit                 row_taken [NROW];
  bit                 col_taken [NCOL];
  logic [3:0]         pivot_col [NROW];
  logic [3:0]         free_cols [NCOL];
  logic [3:0]         rank_q;
  bit                 sat_q;
  logic [2:0]         rows_reg;
  logic [4:0]         cols_reg;
  logic [24:0]        tol_reg;

  res_t expected_results[$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(SMAX)) begin
      sat_q = 1;
      return SMAX;
    end
    if (v < longint'(SMIN)) begin
      sat_q = 1;
      return SMIN;
    end
    return v[31:0];
  endfunction

  function automatic longint absval(logic signed [31:0] a);
    longint v;
    v = a;
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] apply_sign(longint m, bit neg);
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    return clamp32(neg ? -m : m);
  endfunction

  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint m;
    m = (absval(a) * absval(b)) >>> FB;
    return apply_sign(m, a[31] != b[31]);
  endfunction

  function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] b);
    longint ua, ub, q, r;
    ua = absval(a);
    ub = absval(b);
    if (ub == 0) begin
      sat_q = 1;
      return a[31] ? SMIN : SMAX;
    end
    q = ua / ub;
    r = ua % ub;
    for (int n = 0; n < FB; n++) begin
      if (q >= 64'h1_0000_0000) begin
        q = 64'h1_0000_0000;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= ub) begin
        q++;
        r -= ub;
      end
    end
    return apply_sign(q, a[31] != b[31]);
  endfunction

  function automatic int cols_eff();
    if (cols_reg < 1) return 1;
    if (cols_reg > NCOL) return NCOL;
    return cols_reg;
  endfunction

  function automatic int rows_eff(int nc);
    int r;
    r = rows_reg;
    if (r > NROW) r = NROW;
    if (r > nc - 1) r = nc - 1;
    return r;
  endfunction

  // Normalize pivot row, clear pivot column in all other rows
  function automatic void pivot_on(int pr, int pc, int nr, int nc);
    logic signed [31:0] v, f;
    v = store[pr][pc];
    for (int j = 0; j < nc; j++) store[pr][j] = q_div(store[pr][j], v);
    store[pr][BCOL] = q_div(store[pr][BCOL], v);
    store[pr][pc] = clamp32(longint'(1) << FB);
    for (int i = 0; i < nr; i++) begin
      if (i == pr) continue;
      f = store[i][pc];
      for (int j = 0; j < nc; j++)
        store[i][j] = clamp32(longint'(store[i][j]) - longint'(q_mul(f, store[pr][j])));
      store[i][BCOL] = clamp32(longint'(store[i][BCOL]) - longint'(q_mul(f, store[pr][BCOL])));
      store[i][pc] = 0;
    end
  endfunction

  function automatic void split_system(int nr, int nc);
    longint best;
    int bj, br, bc, k;
    bit found;
    logic signed [31:0] s;
    sat_q = 0;
    // Row equilibration by largest A magnitude; all-zero rows stay
    for (int i = 0; i < nr; i++) begin
      best = 0;
      bj = 0;
      for (int j = 0; j < nc; j++)
        if (absval(store[i][j]) > best) begin
          best = absval(store[i][j]);
          bj = j;
        end
      if (best == 0) continue;
      s = store[i][bj];
      if (s[31]) s = clamp32(-longint'(s));
      for (int j = 0; j < nc; j++) store[i][j] = q_div(store[i][j], s);
      store[i][BCOL] = q_div(store[i][BCOL], s);
    end
    foreach (row_taken[i]) row_taken[i] = 0;
    foreach (col_taken[j]) col_taken[j] = 0;
    foreach (pivot_col[i]) pivot_col[i] = 0;
    rank_q = 0;
    while (rank_q < nr) begin
      found = 0;
      best = 0;
      br = 0;
      bc = 0;
      for (int i = 0; i < nr; i++) begin
        if (row_taken[i]) continue;
        for (int j = 0; j < nc; j++) begin
          if (col_taken[j]) continue;
          if (!found || absval(store[i][j]) > best) begin
            found = 1;
            best = absval(store[i][j]);
            br = i;
            bc = j;
          end
        end
      end
      if (!found || best <= longint'(tol_reg)) break;
      pivot_on(br, bc, nr, nc);
      row_taken[br] = 1;
      col_taken[bc] = 1;
      pivot_col[br] = 4'(bc);
      rank_q++;
    end
    foreach (free_cols[j]) free_cols[j] = 0;
    k = 0;
    for (int j = 0; j < nc; j++)
      if (!col_taken[j]) begin
        free_cols[k] = 4'(j);
        k++;
      end
  endfunction

  // Apply one accepted request; push its result if it makes one
  function automatic void accept_request(req_t r);
    int nc, nr;
    res_t e;
    logic signed [31:0] v;
    nc = cols_eff();
    nr = rows_eff(nc);
    e = '0;
    case (r.opcode)
      OP_LOAD_A: store[r.row_index][r.col_index] = r.elem_value;
      OP_LOAD_B: store[r.row_index][BCOL] = r.elem_value;
      default: begin
        if (r.opcode == OP_SOLVE) begin
          split_system(nr, nc);
          e.result_kind = 0;
        end else begin
          e.result_kind = 1;
          if (r.row_index < nr) begin
            e.dependent_col = pivot_col[r.row_index];
            e.offset_value = store[r.row_index][BCOL];
          end
          if (r.col_index < nc - nr) begin
            e.independent_col = free_cols[r.col_index];
            if (r.row_index < nr) begin
              v = store[r.row_index][free_cols[r.col_index]];
              e.coeff_value = (v == SMIN) ? SMAX : -v;
            end
          end
        end
        e.rank_found = rank_q;
        e.full_rank = (rank_q == nr);
        e.overflow = sat_q;
        expected_results.push_back(e);
      end
    endcase
  endfunction

  function automatic void compare_result(res_t a);
    res_t e;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %p", a);
      mismatches++;
      return;
    end
    e = expected_results.pop_front();
    if (a.result_kind !== e.result_kind) begin
      $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind);
      mismatches++;
    end
    if (a.rank_found !== e.rank_found) begin
      $error("rank_found exp %0d got %0d", e.rank_found, a.rank_found);
      mismatches++;
    end
    if (a.full_rank !== e.full_rank) begin
      $error("full_rank exp %0d got %0d", e.full_rank, a.full_rank);
      mismatches++;
    end
    if (a.dependent_col !== e.dependent_col) begin
      $error("dependent_col exp %0d got %0d", e.dependent_col, a.dependent_col);
      mismatches++;
    end
    if (a.independent_col !== e.independent_col) begin
      $error("independent_col exp %0d got %0d", e.independent_col, a.independent_col);
      mismatches++;
    end
    if (a.coeff_value !== e.coeff_value) begin
      $error("coeff_value exp %h got %h", e.coeff_value, a.coeff_value);
      mismatches++;
    end
    if (a.offset_value !== e.offset_value) begin
      $error("offset_value exp %h got %h", e.offset_value, a.offset_value);
      mismatches++;
    end
    if (a.overflow !== e.overflow) begin
      $error("overflow exp %0d got %0d", e.overflow, a.overflow);
      mismatches++;
    end
  endfunction

  // Sample all channels on the rising edge; results first, then new requests
  always @(posedge clk) begin
    if (rst) begin
      foreach (store[i, j]) store[i][j] = 0;
      foreach (row_taken[i]) row_taken[i] = 0;
      foreach (col_taken[j]) col_taken[j] = 0;
      foreach (pivot_col[i]) pivot_col[i] = 0;
      foreach (free_cols[j]) free_cols[j] = 0;
      rank_q = 0;
      sat_q = 0;
      rows_reg = 0;
      cols_reg = 1;
      tol_reg = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (done) compare_result(result);
      if (start && !busy) accept_request(req);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS: rows_reg = cfg_data[2:0];
          CFG_COLS: cols_reg = cfg_data[4:0];
          CFG_TOL:  tol_reg = cfg_data;
          default: ;
        endcase
      end
    end
    awaited = expected_results.size();
  end

endmodule

@@ tb/tb_gauss_jordan_full_pivot_split.sv @@
// Testbench top for gauss_jordan_full_pivot_split: clock, reset, config
// phases and load/solve/read stimulus. Depends on gjfp_pkg, gjfp_split_checker.
`timescale 1ns / 100ps

module tb_gauss_jordan_full_pivot_split;
  import gjfp_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              done;
  res_t              result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                mismatches;
  int                awaited;
  int                nr_cur;
  int                nc_cur;
  int                idle_mode;

  gauss_jordan_full_pivot_split DUT (
    .clk, .rst, .start, .busy, .req, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gjfp_split_checker checker_i (
    .clk, .rst, .start, .busy, .req, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .awaited
  );

  always #5 clk = ~clk;

  // Hard stop if the block hangs
  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    int c;
    c = $urandom_range(99);
    if (c < 70) return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    if (c < 85) return $urandom;
    if (c < 92) return SMAX;
    if (c < 96) return SMIN;
    return 0;
  endfunction

  function automatic int pick_gap();
    int pct;
    pct = (idle_mode == 0) ? 21 : (idle_mode == 1) ? 77 : 0;
    if ($urandom_range(99) < pct) return $urandom_range(1, 4);
    return 0;
  endfunction

  // Hold the request until accepted, then idle for a random gap
  task automatic send(op_t op, int row, int col, logic signed [31:0] val);
    int g;
    req <= '{opcode: op, row_index: 3'(row), col_index: 4'(col), elem_value: val};
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected result has come
  task automatic drain();
    start <= 0;
    do @(negedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, logic [CFG_DW-1:0] tol);
    drain();
    write_reg(CFG_ROWS, CFG_DW'(($urandom & ~32'h7) | rows));
    write_reg(CFG_COLS, CFG_DW'(($urandom & ~32'h1f) | cols));
    write_reg(CFG_TOL, tol);
    nc_cur = (cols < 1) ? 1 : (cols > 16) ? 16 : cols;
    nr_cur = (rows > nc_cur - 1) ? nc_cur - 1 : rows;
  endtask

  // Mostly load-solve-read runs with random content, some stray requests
  task automatic random_traffic(int count);
    int issued, n, row, col;
    bit drained;
    issued = 0;
    drained = 0;
    while (issued < count) begin
      if ($urandom_range(99) < 80) begin
        n = $urandom_range(1, 10);
        issued += n;
        repeat (n) begin
          row = ($urandom_range(9) == 0 || nr_cur == 0) ? $urandom_range(7)
                                                        : $urandom_range(nr_cur - 1);
          if ($urandom_range(3) == 0) send(OP_LOAD_B, row, $urandom_range(15), pick_value());
          else send(OP_LOAD_A, row, $urandom_range(nc_cur - 1), pick_value());
        end
        send(OP_SOLVE, $urandom_range(7), $urandom_range(15), $urandom);
        issued++;
        n = $urandom_range(1, 6);
        issued += n;
        repeat (n) begin
          row = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(nr_cur);
          col = ($urandom_range(4) == 0) ? $urandom_range(15)
                                         : $urandom_range(nc_cur - nr_cur);
          send(OP_READ, row, col, $urandom);
        end
      end else begin
        send(op_t'($urandom_range(3)), $urandom_range(7), $urandom_range(15), $urandom);
        issued++;
      end
      if (!drained && issued >= count / 2) begin
        drain();
        drained = 1;
      end
    end
  endtask

  initial begin
    clk = 0;
    rst = 1;
    start = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    idle_mode = 0;
    nr_cur = 0;
    nc_cur = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Zero rows at reset settings: empty solve, reads with rows out of range
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 7, 15, 0);

    // Write the whole store once so nothing is read unwritten
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 16; c++) send(OP_LOAD_A, r, c, pick_value());
      send(OP_LOAD_B, r, 0, pick_value());
    end

    // Extremes, an all-zero row, then a full-rank system
    configure(2, 3, 0);
    send(OP_LOAD_A, 0, 0, SMAX);
    send(OP_LOAD_A, 0, 1, SMIN);
    send(OP_LOAD_A, 0, 2, 0);
    send(OP_LOAD_A, 1, 0, 0);
    send(OP_LOAD_A, 1, 1, 0);
    send(OP_LOAD_A, 1, 2, 0);
    send(OP_LOAD_B, 0, 0, SMIN);
    send(OP_LOAD_B, 1, 0, 32'sh0100_0000);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 0, 1, 0);
    send(OP_READ, 2, 0, 0);
    send(OP_LOAD_A, 1, 0, 32'sh0100_0000);
    send(OP_LOAD_A, 1, 1, 32'sh0200_0000);
    send(OP_LOAD_A, 1, 2, -32'sh0100_0000);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 1, 0, 0);

    // Random phases across register settings and idle patterns
    random_traffic(150);
    configure(7, 16, 0);
    random_traffic(230);
    configure(3, 8, 25'h001_0000);
    random_traffic(230);
    idle_mode = 1;
    configure(7, 0, 25'h1ff_ffff);
    random_traffic(150);
    configure(5, 31, 25'h100_0000);
    random_traffic(230);
    configure(0, 5, 0);
    random_traffic(200);
    idle_mode = 2;
    configure(4, 6, CFG_DW'($urandom_range(0, 32'h0010_0000)));
    random_traffic(230);
    configure(7, 16, 25'h000_1000);
    random_traffic(230);
    configure(1, 2, 0);
    random_traffic(200);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
